@@ rtl/gtht_pkg.sv @@
// Shared types and constants for the generation tagged handle table.
package gtht_pkg;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned ID_W = 32;
  localparam int unsigned GEN_W = ID_W - IDX_W;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] idx;
  } fq_ent_t;

endpackage

@@ rtl/generation_tagged_handle_table_unit.sv @@
// Generation tagged handle table: slot store, free queue and request datapath.
//
// One request (insert, delete or lookup) is taken per clock whenever start_i is
// high and busy_o is low; busy_o is high only in the first cycle after reset.
// Its result appears on done_o and the result ports at the clock edge after the
// request is taken, for one cycle; the receiver cannot stall, so one result
// leaves per cycle at the same rate requests come in. Slot memories are read
// at the request edge and updated at the next edge, with a bypass from the
// request just ahead, so back-to-back requests to the same slot are handled.
module generation_tagged_handle_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] handle_id_i,
  input  logic [31:0] payload_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] id_out_o,
  output logic [31:0] data_out_o,
  output logic [6:0]  live_count_o
);

  localparam int unsigned SLOTS = gtht_pkg::SLOTS;
  localparam int unsigned IDX_W = gtht_pkg::IDX_W;
  localparam int unsigned GEN_W = gtht_pkg::GEN_W;
  localparam int unsigned CNT_W = gtht_pkg::CNT_W;
  localparam int unsigned DATA_W = gtht_pkg::DATA_W;

  // memories
  logic [GEN_W-1:0]  ident_mem [SLOTS];
  logic [DATA_W-1:0] data_mem  [SLOTS];
  gtht_pkg::fq_ent_t fq_mem    [SLOTS];

  // flop state
  logic              busy_q;
  logic [SLOTS-1:0]  live_q, live_d;
  logic [SLOTS-1:0]  gen_vld_q, gen_vld_d;
  logic [SLOTS-1:0]  fq_vld_q, fq_vld_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]  occ_cnt_q, occ_cnt_d;

  // request stage
  logic              p_vld_q;
  logic [1:0]        p_req_q;
  logic [31:0]       p_id_q;
  logic [DATA_W-1:0] p_pay_q;
  logic [GEN_W-1:0]  ident_rd_q;
  logic              ident_vld_q;
  logic              ident_byp_q;
  logic [GEN_W-1:0]  ident_byp_val_q;
  logic [DATA_W-1:0] data_rd_q;
  logic              data_byp_q;
  logic [DATA_W-1:0] data_byp_val_q;
  gtht_pkg::fq_ent_t fq_rd_q;
  logic              fq_vld_rd_q;
  logic              fq_byp_q;
  gtht_pkg::fq_ent_t fq_byp_val_q;

  // result registers
  logic              done_q;
  logic [1:0]        status_q;
  logic [31:0]       id_out_q;
  logic [DATA_W-1:0] data_out_q;
  logic [CNT_W-1:0]  live_cnt_q;

  logic              accept;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  h_idx;
  logic [GEN_W-1:0]  cur_gen;
  logic [GEN_W-1:0]  gen_nxt;
  logic [DATA_W-1:0] cur_data;
  gtht_pkg::fq_ent_t head_ent;
  gtht_pkg::fq_ent_t tail_ent;
  logic              ins_req, del_req, look_req;
  logic              hit, ins_ok, del_ok;
  logic [1:0]        status_d;
  logic [31:0]       id_out_d;
  logic [DATA_W-1:0] data_out_d;

  assign accept = start_i && !busy_q;
  assign rd_idx = handle_id_i[IDX_W-1:0];
  assign h_idx  = p_id_q[IDX_W-1:0];

  // resolve read data against the write of the request just ahead
  always_comb begin
    if (ident_byp_q) begin
      cur_gen = ident_byp_val_q;
    end else if (ident_vld_q) begin
      cur_gen = ident_rd_q;
    end else begin
      cur_gen = '0;
    end
    cur_data = data_byp_q ? data_byp_val_q : data_rd_q;
    if (fq_byp_q) begin
      head_ent = fq_byp_val_q;
    end else if (fq_vld_rd_q) begin
      head_ent = fq_rd_q;
    end else begin
      head_ent.gen = '0;
      head_ent.idx = head_q;
    end
  end

  always_comb begin
    ins_req  = p_vld_q && (p_req_q == gtht_pkg::REQ_INSERT);
    del_req  = p_vld_q && (p_req_q == gtht_pkg::REQ_DELETE);
    look_req = p_vld_q && (p_req_q == gtht_pkg::REQ_LOOKUP);
    hit      = live_q[h_idx] && (cur_gen == p_id_q[31:IDX_W]);
    ins_ok   = ins_req && (free_cnt_q != '0);
    del_ok   = del_req && hit;
    gen_nxt  = cur_gen + GEN_W'(1);
    tail_ent.gen = gen_nxt;
    tail_ent.idx = h_idx;
  end

  // next state
  always_comb begin
    live_d     = live_q;
    gen_vld_d  = gen_vld_q;
    fq_vld_d   = fq_vld_q;
    head_d     = head_q + IDX_W'(ins_ok);
    tail_d     = tail_q + IDX_W'(del_ok);
    free_cnt_d = free_cnt_q;
    occ_cnt_d  = occ_cnt_q;
    if (ins_ok) begin
      live_d[head_ent.idx] = 1'b1;
      free_cnt_d = free_cnt_q - CNT_W'(1);
      occ_cnt_d  = occ_cnt_q + CNT_W'(1);
    end
    if (del_ok) begin
      live_d[h_idx]    = 1'b0;
      gen_vld_d[h_idx] = 1'b1;
      fq_vld_d[tail_q] = 1'b1;
      free_cnt_d = free_cnt_q + CNT_W'(1);
      occ_cnt_d  = occ_cnt_q - CNT_W'(1);
    end
  end

  // result
  always_comb begin
    status_d   = gtht_pkg::ST_MISS;
    id_out_d   = '0;
    data_out_d = '0;
    if (ins_req) begin
      if (ins_ok) begin
        status_d = gtht_pkg::ST_OK;
        id_out_d = head_ent;
      end else begin
        status_d = gtht_pkg::ST_FULL;
      end
    end else if ((del_req || look_req) && hit) begin
      status_d   = gtht_pkg::ST_OK;
      data_out_d = cur_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      live_q     <= '0;
      gen_vld_q  <= '0;
      fq_vld_q   <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      free_cnt_q <= CNT_W'(SLOTS);
      occ_cnt_q  <= '0;
      p_vld_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      live_q     <= live_d;
      gen_vld_q  <= gen_vld_d;
      fq_vld_q   <= fq_vld_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      free_cnt_q <= free_cnt_d;
      occ_cnt_q  <= occ_cnt_d;
      p_vld_q    <= accept;
      done_q     <= p_vld_q;
    end
  end

  // request beat and bypass capture
  always_ff @(posedge clk_i) begin
    p_req_q         <= req_type_i;
    p_id_q          <= handle_id_i;
    p_pay_q         <= payload_i;
    ident_vld_q     <= gen_vld_q[rd_idx];
    ident_byp_q     <= del_ok && (h_idx == rd_idx);
    ident_byp_val_q <= gen_nxt;
    data_byp_q      <= ins_ok && (head_ent.idx == rd_idx);
    data_byp_val_q  <= p_pay_q;
    fq_vld_rd_q     <= fq_vld_q[head_d];
    fq_byp_q        <= del_ok && (tail_q == head_d);
    fq_byp_val_q    <= tail_ent;
    status_q        <= status_d;
    id_out_q        <= id_out_d;
    data_out_q      <= data_out_d;
    live_cnt_q      <= occ_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (del_ok) begin
      ident_mem[h_idx] <= gen_nxt;
    end
    ident_rd_q <= ident_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (ins_ok) begin
      data_mem[head_ent.idx] <= p_pay_q;
    end
    data_rd_q <= data_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (del_ok) begin
      fq_mem[tail_q] <= tail_ent;
    end
    fq_rd_q <= fq_mem[head_d];
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign id_out_o     = id_out_q;
  assign data_out_o   = data_out_q;
  assign live_count_o = live_cnt_q;

endmodule

@@ sim/generation_tagged_handle_table_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the generation tagged handle table unit.
module generation_tagged_handle_table_unit_tb;

  localparam int unsigned SLOTS = gtht_pkg::SLOTS;
  localparam int unsigned IDX_W = gtht_pkg::IDX_W;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned GEN_STEP = 64;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned RANDOM_BEATS = 1200;

  typedef enum {PICK_RAW, PICK_LIVE, PICK_FREE, PICK_OTHER_GEN} pick_e;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] handle;
    logic [31:0] payload;
    pick_e       pick;
    bit          drain;
  } req_beat_t;

  typedef struct {
    gtht_pkg::status_e status;
    logic [31:0]       id;
    logic [31:0]       data;
    logic [6:0]        live;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = gtht_pkg::REQ_INSERT;
  logic [31:0] handle_id_i = '0;
  logic [31:0] payload_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] id_out_o;
  logic [31:0] data_out_o;
  logic [6:0]  live_count_o;

  // table shadow
  logic [31:0]      ident_tab [SLOTS];
  logic [31:0]      data_tab [SLOTS];
  bit               live_tab [SLOTS];
  logic [IDX_W-1:0] free_ring [SLOTS];
  logic [IDX_W-1:0] ring_head;
  logic [IDX_W-1:0] ring_tail;
  int               free_slots;
  int               occupied;

  req_beat_t pending[$];
  answer_t   answers_due[$];
  int        beats_sent = 0;
  int        beats_taken = 0;
  bit        beat_open = 1'b0;
  int        idle_left = 0;
  int        errors = 0;

  generation_tagged_handle_table_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .handle_id_i  (handle_id_i),
    .payload_i    (payload_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .id_out_o     (id_out_o),
    .data_out_o   (data_out_o),
    .live_count_o (live_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic predict_answer(input logic [1:0] req, input logic [31:0] handle,
                                input logic [31:0] pay, output answer_t ans);
    logic [IDX_W-1:0] idx;
    bit               hit;
    idx = handle[IDX_W-1:0];
    hit = live_tab[idx] && (ident_tab[idx] == handle);
    ans.status = gtht_pkg::ST_MISS;
    ans.id = '0;
    ans.data = '0;
    case (req)
      gtht_pkg::REQ_INSERT: begin
        if (free_slots == 0) begin
          ans.status = gtht_pkg::ST_FULL;
        end else begin
          idx = free_ring[ring_head];
          ring_head = ring_head + IDX_W'(1);
          free_slots--;
          live_tab[idx] = 1'b1;
          data_tab[idx] = pay;
          occupied++;
          ans.id = ident_tab[idx];
          ans.status = gtht_pkg::ST_OK;
        end
      end
      gtht_pkg::REQ_DELETE: begin
        if (hit) begin
          ans.data = data_tab[idx];
          ident_tab[idx] = ident_tab[idx] + GEN_STEP;
          live_tab[idx] = 1'b0;
          free_ring[ring_tail] = idx;
          ring_tail = ring_tail + IDX_W'(1);
          free_slots++;
          occupied--;
          ans.status = gtht_pkg::ST_OK;
        end
      end
      gtht_pkg::REQ_LOOKUP: begin
        if (hit) begin
          ans.data = data_tab[idx];
          ans.status = gtht_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    ans.live = occupied[6:0];
  endtask

  task automatic add_beat(input logic [1:0] req, input pick_e pick, input logic [31:0] handle,
                          input logic [31:0] pay, input bit drain);
    req_beat_t b;
    b.req = req;
    b.pick = pick;
    b.handle = handle;
    b.payload = pay;
    b.drain = drain;
    pending.push_back(b);
  endtask

  always @(posedge clk_i) begin : monitor
    answer_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with none expected: status %0d id %h data %h live %0d",
                   $time, status_o, id_out_o, data_out_o, live_count_o);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (id_out_o !== want.id) begin
            $display("%0t: id_out expected %h actual %h", $time, want.id, id_out_o);
            errors++;
          end
          if (data_out_o !== want.data) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data, data_out_o);
            errors++;
          end
          if (live_count_o !== want.live) begin
            $display("%0t: live_count expected %0d actual %0d", $time, want.live, live_count_o);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_answer(req_type_i, handle_id_i, payload_i, want);
        answers_due.push_back(want);
        beats_taken++;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    req_beat_t        b;
    int               base;
    int               k;
    logic [IDX_W-1:0] slot;
    bit               found;
    if (rst_ni) begin
      if (beat_open && beats_taken == beats_sent) begin
        beat_open = 1'b0;
        if (pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          idle_left = $urandom_range(1, 16);
      end
      if (!beat_open) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
        end else if (pending.size() != 0 && !(pending[0].drain && answers_due.size() != 0)) begin
          b = pending.pop_front();
          if (b.pick != PICK_RAW) begin
            // pick a slot against the table state this beat will see
            base = $urandom_range(0, SLOTS - 1);
            found = 1'b0;
            slot = '0;
            for (k = 0; k < SLOTS && !found; k++) begin
              slot = IDX_W'((base + k) % SLOTS);
              if (b.pick == PICK_OTHER_GEN || live_tab[slot] == (b.pick == PICK_LIVE))
                found = 1'b1;
            end
            if (found) begin
              b.handle = ident_tab[slot];
              if (b.pick == PICK_OTHER_GEN)
                b.handle = $urandom_range(0, 1) ? b.handle + GEN_STEP * $urandom_range(1, 3)
                                                : b.handle - GEN_STEP;
            end
          end
          req_type_i <= b.req;
          handle_id_i <= b.handle;
          payload_i <= b.payload;
          start_i <= 1'b1;
          beat_open = 1'b1;
          beats_sent++;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int         i;
    int         bias;
    int         roll;
    logic [1:0] r;
    pick_e      pk;
    for (i = 0; i < SLOTS; i++) begin
      ident_tab[i] = i;
      data_tab[i] = '0;
      live_tab[i] = 1'b0;
      free_ring[i] = IDX_W'(i);
    end
    ring_head = '0;
    ring_tail = '0;
    free_slots = SLOTS;
    occupied = 0;

    add_beat(gtht_pkg::REQ_LOOKUP, PICK_RAW, 32'h0, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_DELETE, PICK_RAW, 32'h0, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_INSERT, PICK_RAW, 32'h0, 32'h0, 1'b0);
    add_beat(gtht_pkg::REQ_INSERT, PICK_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_beat(gtht_pkg::REQ_INSERT, PICK_RAW, $urandom, 32'hA5A5_5A5A, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_RAW, 32'h0, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_RAW, 32'h1, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_LIVE, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_OTHER_GEN, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_FREE, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_RAW, 32'hFFFF_FFFF, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_DELETE, PICK_RAW, 32'h0, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_DELETE, PICK_RAW, 32'h0, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_RAW, 32'h40, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_INSERT, PICK_RAW, $urandom, $urandom, 1'b0);
    add_beat(REQ_UNUSED, PICK_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_beat(REQ_UNUSED, PICK_LIVE, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_DELETE, PICK_OTHER_GEN, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_DELETE, PICK_FREE, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_DELETE, PICK_LIVE, $urandom, $urandom, 1'b0);
    add_beat(gtht_pkg::REQ_LOOKUP, PICK_LIVE, $urandom, $urandom, 1'b0);

    // phases with different insert mix drive the table from empty to full and back
    while (pending.size() < RANDOM_BEATS + 20) begin
      case ($urandom_range(0, 3))
        0: bias = 10;
        1: bias = 50;
        2: bias = 85;
        default: bias = 97;
      endcase
      repeat ($urandom_range(40, 120)) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) r = REQ_UNUSED;
        else if ($urandom_range(0, 99) < bias) r = gtht_pkg::REQ_INSERT;
        else r = $urandom_range(0, 1) ? gtht_pkg::REQ_DELETE : gtht_pkg::REQ_LOOKUP;
        case ($urandom_range(0, 9))
          0: pk = PICK_RAW;
          1: pk = $urandom_range(0, 1) ? PICK_FREE : PICK_OTHER_GEN;
          default: pk = PICK_LIVE;
        endcase
        add_beat(r, pk, $urandom, $urandom, pending.size() == 600);
      end
    end

    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || beat_open) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
